// File: design/byvc_pkg.sv
package byvc_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 32;
    localparam int PAIR_AW     = 16;
    localparam int PAIR_DEPTH  = 65536;
    localparam int TOTAL_DEPTH = 256;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [2:0] {
        OP_KEY      = 3'd0,
        OP_ENC      = 3'd1,
        OP_DEC      = 3'd2,
        OP_TALLY    = 3'd3,
        OP_RD_PAIR  = 3'd4,
        OP_RD_TOTAL = 3'd5,
        OP_REWIND   = 3'd6,
        OP_CLEAR    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY_RD,
        S_KEY_USE,
        S_CNT_USE
    } t_state;

    // Requests to the key store
    typedef struct packed {
        logic              rd_en;
        logic              add_en;
        logic              space_en;
        logic              advance;
        logic              rewind;
        logic [BYTE_W-1:0] add_byte;
    } t_key_req;

    // Requests to the statistics store
    typedef struct packed {
        logic               rd_en;
        logic               bump_en;
        logic               clear_start;
        logic [PAIR_AW-1:0] pair_addr;
        logic [BYTE_W-1:0]  total_addr;
    } t_stat_req;

endpackage

// File: design/byvc_key_store.sv
module byvc_key_store #(
    parameter int MAX_KEYS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  byvc_pkg::t_key_req           i_req,
    output logic [byvc_pkg::BYTE_W-1:0]  o_key,
    output logic                         o_full
);

    localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [byvc_pkg::BYTE_W-1:0] r_mem [MAX_KEYS];
    logic [byvc_pkg::BYTE_W-1:0] r_rd_q;
    logic [byvc_pkg::BYTE_W-1:0] r_last_key;
    logic [CW-1:0]               r_count;
    logic [KW-1:0]               r_pos;
    logic                        r_hit;
    logic [KW-1:0]               w_last;
    logic [CW-1:0]               w_next_pos;

    assign w_last     = KW'(r_count - CW'(1));
    assign w_next_pos = CW'(r_pos) + CW'(1);
    assign o_full     = (r_count == CW'(MAX_KEYS));

    // Last key lives in a register until a space commits it
    assign o_key = r_hit ? r_last_key : r_rd_q;

    // Read the key at the current position
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_q <= r_mem[r_pos];
        end
        if (i_req.space_en && !o_full) begin
            r_mem[w_last] <= r_last_key;
        end
    end

    // Track key count, open word and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CW'(1);
            r_pos      <= '0;
            r_last_key <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_hit <= (r_pos == w_last);
            end
            if (i_req.space_en && !o_full) begin
                r_last_key <= '0;
                r_count    <= r_count + CW'(1);
            end else if (i_req.add_en) begin
                r_last_key <= r_last_key + i_req.add_byte;
            end
            if (i_req.rewind) begin
                r_pos <= '0;
            end else if (i_req.advance) begin
                r_pos <= (w_next_pos >= r_count) ? '0 : KW'(w_next_pos);
            end
        end
    end

endmodule

// File: design/byvc_stat_store.sv
module byvc_stat_store #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  byvc_pkg::t_stat_req     i_req,
    output logic [COUNT_WIDTH-1:0]  o_pair_q,
    output logic [COUNT_WIDTH-1:0]  o_total_q,
    output logic                    o_busy
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0]        r_pair_mem  [byvc_pkg::PAIR_DEPTH];
    logic [COUNT_WIDTH-1:0]        r_total_mem [byvc_pkg::TOTAL_DEPTH];
    logic [COUNT_WIDTH-1:0]        r_pair_q;
    logic [COUNT_WIDTH-1:0]        r_total_q;
    logic [byvc_pkg::PAIR_AW-1:0]  r_pair_a;
    logic [byvc_pkg::BYTE_W-1:0]   r_total_a;
    logic [byvc_pkg::PAIR_AW-1:0]  r_clr_addr;
    logic                          r_clr_active;

    assign o_pair_q  = r_pair_q;
    assign o_total_q = r_total_q;
    assign o_busy    = r_clr_active;

    // Read, then write back the bumped counts; the sweep zeroes both memories
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_pair_q  <= r_pair_mem[i_req.pair_addr];
            r_total_q <= r_total_mem[i_req.total_addr];
            r_pair_a  <= i_req.pair_addr;
            r_total_a <= i_req.total_addr;
        end
        if (r_clr_active) begin
            r_pair_mem[r_clr_addr]                              <= '0;
            r_total_mem[r_clr_addr[byvc_pkg::BYTE_W-1:0]]       <= '0;
        end else if (i_req.bump_en) begin
            r_pair_mem[r_pair_a]   <= (r_pair_q == CNT_MAX) ? CNT_MAX
                                                            : r_pair_q + COUNT_WIDTH'(1);
            r_total_mem[r_total_a] <= (r_total_q == CNT_MAX) ? CNT_MAX
                                                             : r_total_q + COUNT_WIDTH'(1);
        end
    end

    // Run the clearing sweep after reset and on a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + byvc_pkg::PAIR_AW'(1);
            if (&r_clr_addr) begin
                r_clr_active <= 1'b0;
            end
        end else if (i_req.clear_start) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end
    end

endmodule

// File: design/byte_vigenere_cipher_with_stats_unit.sv
// Sequence: an accepted transaction passes through the key read and key use states, and
//   tally and both reads also through the counter use state, before the registered result strobe.
// The unit takes no new transaction until it returns to idle: busy covers the key memory read
//   followed by the counter memory read and write-back; clear then holds busy through the sweep.
// Reset (synchronous, active low): one key of zero, position zero, then a sweep
//   zeroes all counters with busy high. The receiver cannot stall results.
module byte_vigenere_cipher_with_stats_unit #(
    parameter int MAX_KEYS    = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_operation,
    input  logic [byvc_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic [byvc_pkg::BYTE_W-1:0]        i_plain_byte,
    output logic                               o_strobe,
    output logic [byvc_pkg::BYTE_W-1:0]        o_result_byte,
    output logic [byvc_pkg::OUT_W-1:0]         o_count_value,
    output logic                               o_key_overflow
);

    byvc_pkg::t_state             r_state, n_state;
    byvc_pkg::t_op                r_op;
    logic [byvc_pkg::BYTE_W-1:0]  r_data;
    logic [byvc_pkg::BYTE_W-1:0]  r_plain;
    logic                         r_strobe, n_strobe;
    logic [byvc_pkg::BYTE_W-1:0]  r_res, n_res;
    logic [byvc_pkg::OUT_W-1:0]   r_cnt, n_cnt;
    logic                         r_ovf, n_ovf;

    byvc_pkg::t_key_req           w_key_req;
    byvc_pkg::t_stat_req          w_stat_req;
    logic [byvc_pkg::BYTE_W-1:0]  w_key;
    logic                         w_full;
    logic [COUNT_WIDTH-1:0]       w_pair_q;
    logic [COUNT_WIDTH-1:0]       w_total_q;
    logic                         w_stat_busy;
    logic [byvc_pkg::BYTE_W-1:0]  w_plain_calc;
    logic [byvc_pkg::OUT_W-1:0]   w_pair_out;
    logic [byvc_pkg::OUT_W-1:0]   w_total_out;
    logic                         w_accept;

    assign busy     = (r_state != byvc_pkg::S_IDLE) || w_stat_busy;
    assign w_accept = start && !busy;

    assign o_strobe       = r_strobe;
    assign o_result_byte  = r_res;
    assign o_count_value  = r_cnt;
    assign o_key_overflow = r_ovf;

    assign w_plain_calc = r_data - w_key;

    // Saturate counts to the output width
    generate
        if (COUNT_WIDTH > byvc_pkg::OUT_W) begin : g_clip
            assign w_pair_out  = (|w_pair_q[COUNT_WIDTH-1:byvc_pkg::OUT_W])
                               ? '1 : byvc_pkg::OUT_W'(w_pair_q);
            assign w_total_out = (|w_total_q[COUNT_WIDTH-1:byvc_pkg::OUT_W])
                               ? '1 : byvc_pkg::OUT_W'(w_total_q);
        end else begin : g_ext
            assign w_pair_out  = byvc_pkg::OUT_W'(w_pair_q);
            assign w_total_out = byvc_pkg::OUT_W'(w_total_q);
        end
    endgenerate

    byvc_key_store #(
        .MAX_KEYS (MAX_KEYS)
    ) u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_key_req),
        .o_key   (w_key),
        .o_full  (w_full)
    );

    byvc_stat_store #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_stat_req),
        .o_pair_q  (w_pair_q),
        .o_total_q (w_total_q),
        .o_busy    (w_stat_busy)
    );

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= byvc_pkg::t_op'(i_operation);
            r_data  <= i_data_byte;
            r_plain <= i_plain_byte;
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= byvc_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_res    <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_res    <= n_res;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
        end
    end

    // Sequence key read, counter read and write-back
    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_res      = '0;
        n_cnt      = '0;
        n_ovf      = 1'b0;
        w_key_req  = '0;
        w_stat_req = '0;
        w_key_req.add_byte = r_data;

        case (r_state)
            byvc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = byvc_pkg::S_KEY_RD;
                end
            end
            byvc_pkg::S_KEY_RD: begin
                w_key_req.rd_en = 1'b1;
                n_state         = byvc_pkg::S_KEY_USE;
            end
            byvc_pkg::S_KEY_USE: begin
                n_state  = byvc_pkg::S_IDLE;
                n_strobe = 1'b1;
                case (r_op)
                    byvc_pkg::OP_KEY: begin
                        if (r_data == byvc_pkg::SPACE_CHAR) begin
                            w_key_req.space_en = 1'b1;
                            n_ovf              = w_full;
                        end else begin
                            w_key_req.add_en = 1'b1;
                        end
                    end
                    byvc_pkg::OP_ENC: begin
                        n_res             = r_data + w_key;
                        w_key_req.advance = 1'b1;
                    end
                    byvc_pkg::OP_DEC: begin
                        n_res             = w_plain_calc;
                        w_key_req.advance = 1'b1;
                    end
                    byvc_pkg::OP_TALLY: begin
                        w_stat_req.rd_en      = 1'b1;
                        w_stat_req.pair_addr  = {w_plain_calc, r_data};
                        w_stat_req.total_addr = w_plain_calc;
                        n_strobe              = 1'b0;
                        n_state               = byvc_pkg::S_CNT_USE;
                    end
                    byvc_pkg::OP_RD_PAIR, byvc_pkg::OP_RD_TOTAL: begin
                        w_stat_req.rd_en      = 1'b1;
                        w_stat_req.pair_addr  = {r_plain, r_data};
                        w_stat_req.total_addr = r_plain;
                        n_strobe              = 1'b0;
                        n_state               = byvc_pkg::S_CNT_USE;
                    end
                    byvc_pkg::OP_REWIND: begin
                        w_key_req.rewind = 1'b1;
                    end
                    byvc_pkg::OP_CLEAR: begin
                        w_stat_req.clear_start = 1'b1;
                    end
                    default: begin
                        n_strobe = 1'b1;
                    end
                endcase
            end
            byvc_pkg::S_CNT_USE: begin
                n_state  = byvc_pkg::S_IDLE;
                n_strobe = 1'b1;
                case (r_op)
                    byvc_pkg::OP_TALLY: begin
                        w_stat_req.bump_en = 1'b1;
                        w_key_req.advance  = 1'b1;
                    end
                    byvc_pkg::OP_RD_PAIR: begin
                        n_cnt = w_pair_out;
                    end
                    byvc_pkg::OP_RD_TOTAL: begin
                        n_cnt = w_total_out;
                    end
                    default: begin
                        n_cnt = '0;
                    end
                endcase
            end
            default: begin
                n_state = byvc_pkg::S_IDLE;
            end
        endcase
    end

    // An accepted transaction raises busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after accept");

    // A result appears only after a key-use or counter-use cycle
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == byvc_pkg::S_KEY_USE)
                  || ($past(r_state) == byvc_pkg::S_CNT_USE))
        else $error("strobe without a finished transaction");

    // Overflow only on a key transaction, which carries no cipher byte
    a_ovf_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_overflow |-> o_strobe && (o_result_byte == '0) && (o_count_value == '0))
        else $error("overflow on a non-key result");

    // Counts show only on a result cycle
    a_cnt_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_count_value != '0) |-> o_strobe)
        else $error("count value outside a result");

endmodule

// File: tb/tb_byte_vigenere_cipher_with_stats_unit.sv
`timescale 1ns / 1ps

module tb_byte_vigenere_cipher_with_stats_unit;

    localparam int KEY_SLOTS  = 64;
    localparam int KEY_AW     = $clog2(KEY_SLOTS);
    localparam int QUIET_MAX  = 250000;
    localparam int SHOW_FAULT = 10;

    typedef struct packed {
        logic [byvc_pkg::BYTE_W-1:0] result_byte;
        logic [byvc_pkg::OUT_W-1:0]  count_value;
        logic                        key_overflow;
    } t_cipher_reply;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [2:0]                  i_operation;
    logic [byvc_pkg::BYTE_W-1:0] i_data_byte;
    logic [byvc_pkg::BYTE_W-1:0] i_plain_byte;
    logic                        o_strobe;
    logic [byvc_pkg::BYTE_W-1:0] o_result_byte;
    logic [byvc_pkg::OUT_W-1:0]  o_count_value;
    logic                        o_key_overflow;

    // Shadow state of the cipher and its statistics
    bit [byvc_pkg::BYTE_W-1:0] key_bytes [KEY_SLOTS];
    int                        key_total = 1;
    int                        key_ptr = 0;
    bit [byvc_pkg::OUT_W-1:0]  pair_tally [byvc_pkg::PAIR_DEPTH];
    bit [byvc_pkg::OUT_W-1:0]  plain_tally [byvc_pkg::TOTAL_DEPTH];
    logic [15:0]               seen_pairs [$];

    t_cipher_reply   pending_replies [$];
    int              fault_count = 0;
    int              sender_idle_pct = 0;
    int unsigned     quiet_cycles = 0;

    byte_vigenere_cipher_with_stats_unit #(
        .MAX_KEYS    (KEY_SLOTS),
        .COUNT_WIDTH (32)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .i_plain_byte   (i_plain_byte),
        .o_strobe       (o_strobe),
        .o_result_byte  (o_result_byte),
        .o_count_value  (o_count_value),
        .o_key_overflow (o_key_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one accepted transaction to the shadow state and return its reply
    function automatic t_cipher_reply compute_cipher_reply(
            input byvc_pkg::t_op op,
            input logic [byvc_pkg::BYTE_W-1:0] data,
            input logic [byvc_pkg::BYTE_W-1:0] plain);
        t_cipher_reply               reply;
        logic [byvc_pkg::BYTE_W-1:0] key_now;
        logic [byvc_pkg::BYTE_W-1:0] plain_now;
        logic [15:0]                 slot;
        bit                          moves_ptr;
        reply = '0;
        moves_ptr = 1'b0;
        key_now = key_bytes[KEY_AW'(key_ptr)];
        case (op)
            byvc_pkg::OP_KEY: begin
                if (data == byvc_pkg::SPACE_CHAR) begin
                    if (key_total < KEY_SLOTS) begin
                        key_bytes[KEY_AW'(key_total)] = '0;
                        key_total++;
                    end else begin
                        reply.key_overflow = 1'b1;
                    end
                end else begin
                    key_bytes[KEY_AW'(key_total-1)] = key_bytes[KEY_AW'(key_total-1)] + data;
                end
            end
            byvc_pkg::OP_ENC: begin
                reply.result_byte = data + key_now;
                moves_ptr = 1'b1;
            end
            byvc_pkg::OP_DEC: begin
                reply.result_byte = data - key_now;
                moves_ptr = 1'b1;
            end
            byvc_pkg::OP_TALLY: begin
                plain_now = data - key_now;
                slot = {plain_now, data};
                // Hold both counters at their maximum
                if (pair_tally[slot] != '1) pair_tally[slot]++;
                if (plain_tally[plain_now] != '1) plain_tally[plain_now]++;
                seen_pairs.push_back(slot);
                moves_ptr = 1'b1;
            end
            byvc_pkg::OP_RD_PAIR: reply.count_value = pair_tally[{plain, data}];
            byvc_pkg::OP_RD_TOTAL: reply.count_value = plain_tally[plain];
            byvc_pkg::OP_REWIND: key_ptr = 0;
            default: begin
                foreach (pair_tally[i]) pair_tally[i] = '0;
                foreach (plain_tally[i]) plain_tally[i] = '0;
                seen_pairs.delete();
            end
        endcase
        // Advance the key position and wrap over the current key count
        if (moves_ptr) key_ptr = (key_ptr + 1 >= key_total) ? 0 : key_ptr + 1;
        return reply;
    endfunction

    // Drive one transaction from a falling edge and hold it until accepted
    task automatic issue_command(input byvc_pkg::t_op op,
                                 input logic [byvc_pkg::BYTE_W-1:0] data,
                                 input logic [byvc_pkg::BYTE_W-1:0] plain);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_operation = op;
        i_data_byte = data;
        i_plain_byte = plain;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_replies.push_back(compute_cipher_reply(op, data, plain));
        @(negedge i_clk);
    endtask

    // Pause the sender until every expected reply has come back
    task automatic wait_for_replies();
        start = 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_reset_state();
        issue_command(byvc_pkg::OP_ENC, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_DEC, 8'hFF, 8'hFF);
        issue_command(byvc_pkg::OP_RD_TOTAL, 8'h00, 8'h00);
    endtask

    task automatic test_key_loading();
        // Word sum wraps: key 0 becomes 0x01; an empty word gives a zero key
        issue_command(byvc_pkg::OP_KEY, 8'hFF, 8'h00);
        issue_command(byvc_pkg::OP_KEY, 8'h02, 8'hFF);
        issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'h00);
        issue_command(byvc_pkg::OP_KEY, 8'h80, 8'h00);
        issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'h00);
        issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'h00);
        issue_command(byvc_pkg::OP_KEY, 8'h7F, 8'h00);
        issue_command(byvc_pkg::OP_ENC, 8'hFF, 8'h00);
        issue_command(byvc_pkg::OP_ENC, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_DEC, 8'h55, 8'h00);
        issue_command(byvc_pkg::OP_ENC, 8'hAA, 8'h00);
        // Add a key mid-stream; the position must not move
        issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'h00);
        issue_command(byvc_pkg::OP_ENC, 8'h10, 8'h00);
        issue_command(byvc_pkg::OP_DEC, 8'h10, 8'h00);
    endtask

    task automatic test_rewind();
        issue_command(byvc_pkg::OP_REWIND, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_DEC, 8'h01, 8'h00);
    endtask

    task automatic test_statistics();
        issue_command(byvc_pkg::OP_REWIND, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_TALLY, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_REWIND, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_TALLY, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_RD_PAIR, 8'h00, 8'hFF);
        issue_command(byvc_pkg::OP_RD_TOTAL, 8'h00, 8'hFF);
        wait_for_replies();
        issue_command(byvc_pkg::OP_CLEAR, 8'h00, 8'h00);
        issue_command(byvc_pkg::OP_RD_PAIR, 8'h00, 8'hFF);
        issue_command(byvc_pkg::OP_RD_TOTAL, 8'h00, 8'hFF);
    endtask

    task automatic test_key_table_full();
        sender_idle_pct = 10;
        while (key_total < KEY_SLOTS)
            issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'($urandom_range(0, 255)));
        // Drop further spaces; later word bytes add into the last key
        issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'h00);
        issue_command(byvc_pkg::OP_KEY, byvc_pkg::SPACE_CHAR, 8'hFF);
        issue_command(byvc_pkg::OP_KEY, 8'h5A, 8'h00);
        issue_command(byvc_pkg::OP_REWIND, 8'h00, 8'h00);
        repeat (3) issue_command(byvc_pkg::OP_ENC, 8'($urandom_range(0, 255)), 8'h00);
    endtask

    task automatic run_random_traffic(input int items, input int idle_pct);
        int                          clear_slot;
        int                          pick;
        byvc_pkg::t_op               op;
        logic [byvc_pkg::BYTE_W-1:0] data;
        logic [byvc_pkg::BYTE_W-1:0] plain;
        logic [15:0]                 pair;
        sender_idle_pct = idle_pct;
        clear_slot = $urandom_range(items / 4, 3 * items / 4);
        for (int n = 0; n < items; n++) begin
            data = 8'($urandom_range(0, 255));
            plain = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            pair = '0;
            if (seen_pairs.size() != 0) pair = seen_pairs[$urandom_range(0, seen_pairs.size() - 1)];
            if (n == clear_slot) begin
                wait_for_replies();
                op = byvc_pkg::OP_CLEAR;
            end else if (pick < 15) begin
                op = byvc_pkg::OP_KEY;
                if ($urandom_range(0, 3) == 0) data = byvc_pkg::SPACE_CHAR;
            end else if (pick < 35) begin
                op = byvc_pkg::OP_ENC;
            end else if (pick < 55) begin
                op = byvc_pkg::OP_DEC;
            end else if (pick < 80) begin
                op = byvc_pkg::OP_TALLY;
            end else if (pick < 90) begin
                // Mostly query pairs that have been counted
                op = byvc_pkg::OP_RD_PAIR;
                if (seen_pairs.size() != 0 && $urandom_range(0, 9) < 7) begin
                    plain = pair[15:8];
                    data = pair[7:0];
                end
            end else if (pick < 96) begin
                op = byvc_pkg::OP_RD_TOTAL;
                if (seen_pairs.size() != 0 && $urandom_range(0, 9) < 7) plain = pair[15:8];
            end else begin
                op = byvc_pkg::OP_REWIND;
            end
            issue_command(op, data, plain);
        end
    endtask

    // Compare each reply with the oldest expectation
    always @(posedge i_clk) begin
        t_cipher_reply want;
        if (i_rst_n && o_strobe) begin
            if (pending_replies.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_FAULT)
                    $display("unexpected reply: result %02h count %0d overflow %0b",
                             o_result_byte, o_count_value, o_key_overflow);
            end else begin
                want = pending_replies.pop_front();
                if (o_result_byte !== want.result_byte || o_count_value !== want.count_value
                        || o_key_overflow !== want.key_overflow) begin
                    fault_count++;
                    if (fault_count <= SHOW_FAULT)
                        $display("reply mismatch: result %02h/%02h count %0d/%0d overflow %0b/%0b",
                                 want.result_byte, o_result_byte, want.count_value,
                                 o_count_value, want.key_overflow, o_key_overflow);
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > QUIET_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = byvc_pkg::OP_KEY;
        i_data_byte = '0;
        i_plain_byte = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_key_loading();
        test_rewind();
        test_statistics();
        run_random_traffic(260, 30);
        test_key_table_full();
        run_random_traffic(260, 79);
        run_random_traffic(260, 0);

        // Drain, then give the block time to show any stray reply
        wait_for_replies();
        repeat (20) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
